// ===== rtl/i2c_master_register_access_macros.svh =====
// Assertion macros for the I2C master register access block.
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2CMRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CMRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/i2cmra_pkg.sv =====
// Types, codes and helpers for the I2C master register access block.
package i2cmra_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WORD  = 2'd3;

  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd208;

  localparam logic [5:0] START_STOP_LAST = 6'd2;
  localparam logic [5:0] BYTE_LAST       = 6'd17;

  typedef enum logic [1:0] {
    SEG_START,
    SEG_WBYTE,
    SEG_RBYTE,
    SEG_STOP
  } seg_kind_t;

  // Segment kind for a given transaction type and segment index.
  function automatic seg_kind_t seg_kind(input logic [1:0] lop, input logic [2:0] step);
    seg_kind_t kind;
    kind = SEG_STOP;
    if (lop == OP_WRITE) begin
      case (step)
        3'd0: kind = SEG_START;
        3'd1, 3'd2, 3'd3: kind = SEG_WBYTE;
        default: kind = SEG_STOP;
      endcase
    end else begin
      case (step)
        3'd0, 3'd3: kind = SEG_START;
        3'd1, 3'd2, 3'd4: kind = SEG_WBYTE;
        3'd5: kind = SEG_RBYTE;
        default: kind = SEG_STOP;
      endcase
    end
    return kind;
  endfunction

endpackage

// ===== rtl/i2c_master_register_access.sv =====
// I2C master register access: one half-bit tick per request, result registered.
// The result of an accepted request appears on the output register in the next cycle.
// Throughput: one request per cycle while the output is not stalled; the whole tick is one pass of logic.
// A request is taken while a result waits, as long as that result is taken too.
// Reset (rst, synchronous): idle bus, output empty, device_address back to 208.
`include "i2c_master_register_access_macros.svh"

module i2c_master_register_access (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl,
  output logic        sda_pull_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [15:0] read_data,
  output logic        ack_error
);

  logic [7:0]  device_address;
  logic [5:0]  phase;
  logic [3:0]  bit_count;
  logic [7:0]  shift_byte;
  logic [2:0]  byte_step;
  logic [15:0] word_result;
  logic        missed_ack;
  logic [1:0]  latched_op;
  logic [7:0]  latched_reg;
  logic [7:0]  latched_data;

  logic [5:0]  phase_next;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_byte_next;
  logic [2:0]  byte_step_next;
  logic [15:0] word_result_next;
  logic        missed_ack_next;
  logic [1:0]  latched_op_next;
  logic [7:0]  latched_reg_next;
  logic [7:0]  latched_data_next;

  logic        scl_next;
  logic        pull_next;
  logic        busy_next;
  logic        done_next;

  logic        in_accept;
  logic        start;
  i2cmra_pkg::seg_kind_t kind;
  logic [5:0]  t;
  logic [5:0]  last;
  logic [7:0]  wbyte;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    start             = (phase == 6'd0) && (op != i2cmra_pkg::OP_TICK);
    latched_op_next   = start ? op : latched_op;
    latched_reg_next  = start ? reg_addr : latched_reg;
    latched_data_next = start ? write_data : latched_data;
    missed_ack_next   = start ? 1'b0 : missed_ack;
    word_result_next  = (start && (op == i2cmra_pkg::OP_READ || op == i2cmra_pkg::OP_WORD))
                        ? 16'd0 : word_result;
    byte_step_next    = start ? 3'd0 : byte_step;
    bit_count_next    = start ? 4'd0 : bit_count;
    phase_next        = start ? 6'd1 : phase;
    shift_byte_next   = shift_byte;

    scl_next  = 1'b1;
    pull_next = 1'b0;
    busy_next = 1'b0;
    done_next = 1'b0;

    kind = i2cmra_pkg::seg_kind(latched_op_next, byte_step_next);
    t    = phase_next - 6'd1;
    last = i2cmra_pkg::START_STOP_LAST;

    if (byte_step_next == 3'd1) begin
      wbyte = device_address;
    end else if (byte_step_next == 3'd2) begin
      wbyte = latched_reg_next;
    end else if (latched_op_next == i2cmra_pkg::OP_WRITE) begin
      wbyte = latched_data_next;
    end else begin
      wbyte = device_address + 8'd1;
    end

    if (phase_next != 6'd0) begin
      busy_next = 1'b1;
      if (kind == i2cmra_pkg::SEG_START || kind == i2cmra_pkg::SEG_STOP) begin
        scl_next = (t != 6'd0);
        if (kind == i2cmra_pkg::SEG_START) begin
          pull_next = (t == 6'd2);
        end else begin
          pull_next = (t != 6'd2);
        end
      end else begin
        last = i2cmra_pkg::BYTE_LAST;
        if (t == 6'd0) begin
          shift_byte_next = (kind == i2cmra_pkg::SEG_WBYTE) ? wbyte : 8'd0;
        end
        bit_count_next = t[4:1];
        scl_next       = t[0];
        if (bit_count_next < 4'd8) begin
          if (kind == i2cmra_pkg::SEG_WBYTE) begin
            pull_next = !shift_byte_next[7];
            if (t[0]) begin
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
            end
          end else if (t[0]) begin
            shift_byte_next = {shift_byte_next[6:0], sda_in};
          end
        end else if (kind == i2cmra_pkg::SEG_WBYTE && t[0] && sda_in) begin
          missed_ack_next = 1'b1;
        end
      end

      if (t >= last) begin
        phase_next     = 6'd1;
        bit_count_next = 4'd0;
        if (kind == i2cmra_pkg::SEG_RBYTE) begin
          word_result_next = {word_result_next[7:0], shift_byte_next};
        end
        if (kind == i2cmra_pkg::SEG_STOP) begin
          byte_step_next = 3'd0;
          if (latched_op_next == i2cmra_pkg::OP_WORD) begin
            latched_op_next  = i2cmra_pkg::OP_READ;
            latched_reg_next = latched_reg_next + 8'd1;
          end else begin
            phase_next = 6'd0;
            done_next  = 1'b1;
          end
        end else begin
          byte_step_next = byte_step_next + 3'd1;
        end
      end else begin
        phase_next = phase_next + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cmra_pkg::DEVICE_ADDRESS_RESET;
    end else if (cfg_write_en) begin
      device_address <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 6'd0;
      bit_count    <= 4'd0;
      shift_byte   <= 8'd0;
      byte_step    <= 3'd0;
      word_result  <= 16'd0;
      missed_ack   <= 1'b0;
      latched_op   <= i2cmra_pkg::OP_TICK;
      latched_reg  <= 8'd0;
      latched_data <= 8'd0;
    end else if (in_accept) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      byte_step    <= byte_step_next;
      word_result  <= word_result_next;
      missed_ack   <= missed_ack_next;
      latched_op   <= latched_op_next;
      latched_reg  <= latched_reg_next;
      latched_data <= latched_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      scl          <= scl_next;
      sda_pull_low <= pull_next;
      busy_res     <= busy_next;
      done_res     <= done_next;
      read_data    <= word_result_next;
      ack_error    <= missed_ack_next;
    end
  end

  `I2CMRA_ASSERT_NOW(a_idle_step_zero, clk, rst, phase == 6'd0, byte_step == 3'd0, "segment index not cleared while idle")
  `I2CMRA_ASSERT_NOW(a_busy_has_op, clk, rst, phase != 6'd0, latched_op != i2cmra_pkg::OP_TICK, "transaction running without an op")
  `I2CMRA_ASSERT_NEXT(a_tick_stays_idle, clk, rst, in_accept && phase == 6'd0 && op == i2cmra_pkg::OP_TICK, phase == 6'd0, "plain tick left idle")
  `I2CMRA_ASSERT_NOW(a_done_is_busy, clk, rst, out_valid && done_res, busy_res, "done without busy")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the I2C master register access block: per-tick pin prediction.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_ITEMS  = 300;
  localparam int STALL_LIMIT  = 200;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda;
  } tick_request_t;

  typedef struct packed {
    logic        scl;
    logic        sda_pull_low;
    logic        busy;
    logic        done;
    logic [15:0] read_data;
    logic        ack_error;
  } pin_state_t;

  typedef enum logic [1:0] {LINE_LOW, LINE_HIGH, LINE_NOISE} line_mode_t;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [7:0]  cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [7:0]  reg_addr;
  logic [7:0]  write_data;
  logic        sda_in;
  logic        out_valid;
  logic        out_stall;
  logic        scl;
  logic        sda_pull_low;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;
  logic        ack_error;

  // bus model state
  logic [5:0]  bus_phase;
  logic [3:0]  bit_idx;
  logic [7:0]  shifter;
  logic [2:0]  seg_index;
  logic [15:0] word_acc;
  logic        nack_seen;
  logic [1:0]  cur_op;
  logic [7:0]  cur_reg;
  logic [7:0]  cur_data;
  logic [7:0]  dev_addr;

  pin_state_t expected_pins[$];
  int         fail_count;
  int         ticks_sent;
  int         idle_cycles;
  int         stall_left;
  bit         quiet;

  i2c_master_register_access uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .reg_addr       (reg_addr),
    .write_data     (write_data),
    .sda_in         (sda_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .scl            (scl),
    .sda_pull_low   (sda_pull_low),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .read_data      (read_data),
    .ack_error      (ack_error)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic i2cmra_pkg::seg_kind_t segment_of(input logic [1:0] lop,
                                                       input logic [2:0] idx);
    if (lop == i2cmra_pkg::OP_WRITE) begin
      if (idx == 3'd0) return i2cmra_pkg::SEG_START;
      if (idx <= 3'd3) return i2cmra_pkg::SEG_WBYTE;
      return i2cmra_pkg::SEG_STOP;
    end
    case (idx)
      3'd0, 3'd3: return i2cmra_pkg::SEG_START;
      3'd1, 3'd2, 3'd4: return i2cmra_pkg::SEG_WBYTE;
      3'd5: return i2cmra_pkg::SEG_RBYTE;
      default: return i2cmra_pkg::SEG_STOP;
    endcase
  endfunction

  function automatic logic line_bit(input line_mode_t mode);
    case (mode)
      LINE_LOW: return 1'b0;
      LINE_HIGH: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic predict_pins(input tick_request_t rq, output pin_state_t rs);
    i2cmra_pkg::seg_kind_t kind;
    logic [5:0] t;
    logic [5:0] seg_end;
    logic       high;
    rs = '0;
    rs.scl = 1'b1;
    if (bus_phase == 6'd0 && rq.op != i2cmra_pkg::OP_TICK) begin
      cur_op = rq.op;
      cur_reg = rq.reg_addr;
      cur_data = rq.write_data;
      nack_seen = 1'b0;
      if (rq.op == i2cmra_pkg::OP_READ || rq.op == i2cmra_pkg::OP_WORD) word_acc = '0;
      seg_index = '0;
      bit_idx = '0;
      bus_phase = 6'd1;
    end
    if (bus_phase != 6'd0) begin
      kind = segment_of(cur_op, seg_index);
      t = bus_phase - 6'd1;
      rs.busy = 1'b1;
      if (kind == i2cmra_pkg::SEG_START || kind == i2cmra_pkg::SEG_STOP) begin
        seg_end = i2cmra_pkg::START_STOP_LAST;
        rs.scl = (t != 6'd0);
        rs.sda_pull_low = (kind == i2cmra_pkg::SEG_START) ? (t == 6'd2) : (t != 6'd2);
      end else begin
        seg_end = i2cmra_pkg::BYTE_LAST;
        high = t[0];
        if (t == 6'd0) begin
          if (kind == i2cmra_pkg::SEG_RBYTE) shifter = '0;
          else if (seg_index == 3'd1) shifter = dev_addr;
          else if (seg_index == 3'd2) shifter = cur_reg;
          else if (cur_op == i2cmra_pkg::OP_WRITE) shifter = cur_data;
          else shifter = dev_addr + 8'd1;
        end
        bit_idx = t[4:1];
        rs.scl = high;
        if (bit_idx < 4'd8) begin
          if (kind == i2cmra_pkg::SEG_WBYTE) begin
            rs.sda_pull_low = ~shifter[7];
            if (high) shifter = shifter << 1;
          end else if (high) begin
            shifter = {shifter[6:0], rq.sda};
          end
        end else if (kind == i2cmra_pkg::SEG_WBYTE && high && rq.sda) begin
          nack_seen = 1'b1;
        end
      end
      if (t >= seg_end) begin
        bus_phase = 6'd1;
        bit_idx = '0;
        if (kind == i2cmra_pkg::SEG_RBYTE) word_acc = {word_acc[7:0], shifter};
        if (kind == i2cmra_pkg::SEG_STOP) begin
          seg_index = '0;
          if (cur_op == i2cmra_pkg::OP_WORD) begin
            cur_op = i2cmra_pkg::OP_READ;
            cur_reg = cur_reg + 8'd1;
          end else begin
            bus_phase = 6'd0;
            rs.done = 1'b1;
          end
        end else begin
          seg_index = seg_index + 3'd1;
        end
      end else begin
        bus_phase = bus_phase + 6'd1;
      end
    end
    rs.read_data = word_acc;
    rs.ack_error = nack_seen;
  endtask

  task automatic send_tick(input logic [1:0] o, input logic [7:0] r, input logic [7:0] d,
                           input logic s);
    tick_request_t rq;
    pin_state_t    rs;
    rq = '{op: o, reg_addr: r, write_data: d, sda: s};
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    reg_addr <= r;
    write_data <= d;
    sda_in <= s;
    do @(posedge clk); while (in_stall);
    predict_pins(rq, rs);
    expected_pins.push_back(rs);
    ticks_sent++;
  endtask

  task automatic run_transfer(input logic [1:0] o, input logic [7:0] r, input logic [7:0] d,
                              input line_mode_t mode);
    send_tick(o, r, d, line_bit(mode));
    while (bus_phase != 6'd0) begin
      send_tick(2'($urandom), 8'($urandom), 8'($urandom), line_bit(mode));
    end
  endtask

  task automatic set_device_address(input logic [7:0] a);
    while (bus_phase != 6'd0) begin
      send_tick(i2cmra_pkg::OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
    end
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= a;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    dev_addr = a;
  endtask

  task automatic test_idle;
    send_tick(i2cmra_pkg::OP_TICK, 8'h00, 8'h00, 1'b0);
    send_tick(i2cmra_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1);
    send_tick(i2cmra_pkg::OP_TICK, 8'h5A, 8'hA5, 1'b0);
  endtask

  task automatic test_write;
    run_transfer(i2cmra_pkg::OP_WRITE, 8'h00, 8'hFF, LINE_LOW);
    run_transfer(i2cmra_pkg::OP_WRITE, 8'hFF, 8'h00, LINE_HIGH);
    run_transfer(i2cmra_pkg::OP_WRITE, 8'hA5, 8'h5A, LINE_NOISE);
  endtask

  task automatic test_read;
    run_transfer(i2cmra_pkg::OP_READ, 8'h3C, 8'hC3, LINE_NOISE);
    run_transfer(i2cmra_pkg::OP_READ, 8'h00, 8'hFF, LINE_HIGH);
    run_transfer(i2cmra_pkg::OP_READ, 8'hFF, 8'h00, LINE_LOW);
    // write keeps the last read value
    run_transfer(i2cmra_pkg::OP_WRITE, 8'h77, 8'h88, LINE_LOW);
  endtask

  task automatic test_word;
    // second register wraps to zero
    run_transfer(i2cmra_pkg::OP_WORD, 8'hFF, 8'h00, LINE_NOISE);
    run_transfer(i2cmra_pkg::OP_WORD, 8'h10, 8'hFF, LINE_HIGH);
  endtask

  task automatic test_address_extremes;
    set_device_address(8'd0);
    run_transfer(i2cmra_pkg::OP_WRITE, 8'h12, 8'h34, LINE_LOW);
    run_transfer(i2cmra_pkg::OP_READ, 8'h56, 8'h00, LINE_NOISE);
    set_device_address(8'd254);
    run_transfer(i2cmra_pkg::OP_WORD, 8'h80, 8'h00, LINE_NOISE);
    // read address wraps to zero
    set_device_address(8'd255);
    run_transfer(i2cmra_pkg::OP_READ, 8'h01, 8'h00, LINE_NOISE);
    set_device_address(i2cmra_pkg::DEVICE_ADDRESS_RESET);
  endtask

  task automatic test_random;
    int         first_tick;
    int         pick;
    logic [7:0] addr;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < RANDOM_ITEMS) begin
      if (ticks_sent - first_tick >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) begin
        pick = int'($urandom_range(0, 5));
        addr = 8'($urandom);
        if (pick == 0) addr = 8'd0;
        else if (pick == 1) addr = 8'd254;
        else if (pick == 2) addr = 8'd255;
        set_device_address(addr);
      end
      repeat ($urandom_range(0, 2)) begin
        send_tick(i2cmra_pkg::OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
      end
      run_transfer(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                   line_mode_t'($urandom_range(0, 2)));
    end
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= int'($urandom_range(0, 2));
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_pins
    pin_state_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pins.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        want = expected_pins.pop_front();
        if (scl !== want.scl) begin
          $error("scl: expected %0d, got %0d", want.scl, scl);
          fail_count++;
        end
        if (sda_pull_low !== want.sda_pull_low) begin
          $error("sda_pull_low: expected %0d, got %0d", want.sda_pull_low, sda_pull_low);
          fail_count++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, busy_res);
          fail_count++;
        end
        if (done_res !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, done_res);
          fail_count++;
        end
        if (read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, read_data);
          fail_count++;
        end
        if (ack_error !== want.ack_error) begin
          $error("ack_error: expected %0d, got %0d", want.ack_error, ack_error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_valid <= 1'b0;
    op <= i2cmra_pkg::OP_TICK;
    reg_addr <= '0;
    write_data <= '0;
    sda_in <= 1'b0;
    ticks_sent = 0;
    quiet = 1'b0;
    bus_phase = '0;
    bit_idx = '0;
    shifter = '0;
    seg_index = '0;
    word_acc = '0;
    nack_seen = 1'b0;
    cur_op = i2cmra_pkg::OP_TICK;
    cur_reg = '0;
    cur_data = '0;
    dev_addr = i2cmra_pkg::DEVICE_ADDRESS_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_idle();
    test_write();
    test_read();
    test_word();
    test_address_extremes();
    test_random();
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
